@@ rtl/acaf_pkg.sv @@
package acaf_pkg;

	// Default filter lengths.
	localparam int HP_TAPS_DEF   = 3;
	localparam int VOL_TAPS_DEF  = 5;
	localparam int BAT_BLOCK_DEF = 12;

	// Converter sample and level width, and the byte-padded stream data width.
	localparam int SAMPLE_W = 10;
	localparam int DATA_W   = 16;
	localparam int CHAN_W   = 2;

	typedef enum logic [CHAN_W-1:0] {
		CH_HP   = 2'd0,
		CH_VOL  = 2'd1,
		CH_BAT  = 2'd2,
		CH_NONE = 2'd3
	} chan_t;

endpackage

@@ rtl/acaf_boxcar.sv @@
module acaf_boxcar #(
	parameter int TAPS = acaf_pkg::HP_TAPS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          upd,
	input  logic [acaf_pkg::SAMPLE_W-1:0] sample,
	output logic [acaf_pkg::SAMPLE_W-1:0] level
);

	localparam int SW  = $clog2(1024 * TAPS);
	localparam int PW  = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int SH  = SW + $clog2(TAPS);
	localparam longint RECIP = ((64'(1) << SH) + TAPS - 1) / TAPS;
	localparam int PRW = SW + SH + 1;

	logic [acaf_pkg::SAMPLE_W-1:0] window_q [TAPS];
	logic [SW-1:0]                 sum_q;
	logic [PW-1:0]                 pos_q;
	logic                          fresh_q;

	logic [SW-1:0]  sum_next;
	logic [SW-1:0]  fill_sum;
	logic [PW-1:0]  pos_next;
	logic [PRW-1:0] prod;

	// Running sum swaps the oldest slot for the new sample.
	assign sum_next = sum_q + SW'(sample) - SW'(window_q[pos_q]);
	assign fill_sum = SW'(SW'(sample) * SW'(TAPS));
	assign pos_next = (pos_q == PW'(TAPS - 1)) ? '0 : PW'(pos_q + 1'b1);

	// Truncating mean: multiply by the rounded-up reciprocal, exact for any sum.
	assign prod  = PRW'(PRW'(sum_next) * PRW'(RECIP));
	assign level = fresh_q ? sample : prod[SH +: acaf_pkg::SAMPLE_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			pos_q   <= '0;
			fresh_q <= 1'b1;
		end else if (upd) begin
			fresh_q <= 1'b0;
			if (fresh_q) begin
				sum_q <= fill_sum;
				pos_q <= '0;
			end else begin
				sum_q <= sum_next;
				pos_q <= pos_next;
			end
		end
	end

	// The first sample fills every slot, so the window needs no reset.
	always_ff @(posedge clk) begin
		if (upd) begin
			for (int i = 0; i < TAPS; i++) begin
				if (fresh_q || (pos_q == PW'(i))) begin
					window_q[i] <= sample;
				end
			end
		end
	end

endmodule

@@ rtl/adc_channel_averaging_filter.sv @@
// Per-channel averaging filter for a 10-bit converter. Each input item is one raw
// sample, tagged in tuser with its channel (0 headphone sense, 1 volume, 2 battery
// voltage), and produces exactly one result item carrying the same channel code and
// that channel's filtered level. Headphone sense and volume are running boxcar
// averages over HP_TAPS and VOL_TAPS samples; the first sample after reset fills
// the whole window and is reported directly. The battery channel reports block
// means over BAT_BLOCK samples; while its level and block count are both zero the
// raw sample is taken as the level without being accumulated. All means truncate.
// Channel code 3 changes nothing and reports level 0. The block accepts one item
// every clock cycle. An accepted item is held in the input register; the filter
// update, which is a single add and a constant-reciprocal multiply, is then
// written into the result register together with the channel state, and the
// result is offered from there. Backpressure on the result side stalls the
// input side.
module adc_channel_averaging_filter #(
	parameter int HP_TAPS   = acaf_pkg::HP_TAPS_DEF,
	parameter int VOL_TAPS  = acaf_pkg::VOL_TAPS_DEF,
	parameter int BAT_BLOCK = acaf_pkg::BAT_BLOCK_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [acaf_pkg::DATA_W-1:0]   s_axis_tdata,  // [9:0] sample, [15:10] zero
	input  logic [acaf_pkg::CHAN_W-1:0]   s_axis_tuser,  // [1:0] func

	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [acaf_pkg::DATA_W-1:0]   m_axis_tdata,  // [9:0] level, [15:10] zero
	output logic [acaf_pkg::CHAN_W-1:0]   m_axis_tuser   // [1:0] channel
);

	localparam int SMP_W = acaf_pkg::SAMPLE_W;
	// Battery accumulator holds at most BAT_BLOCK full-scale samples.
	localparam int BSW   = $clog2(1024 * BAT_BLOCK);
	localparam int CW    = $clog2(BAT_BLOCK + 1);
	localparam int BSH   = BSW + $clog2(BAT_BLOCK);
	localparam longint BAT_RECIP = ((64'(1) << BSH) + BAT_BLOCK - 1) / BAT_BLOCK;
	localparam int BPRW  = BSW + BSH + 1;

	// Input register.
	logic                  valid_s1;
	acaf_pkg::chan_t       func_s1;
	logic [SMP_W-1:0]      sample_s1;

	// Result register.
	logic                  out_valid_q;
	acaf_pkg::chan_t       channel_q;
	logic [SMP_W-1:0]      level_q;

	// Battery state.
	logic [BSW-1:0]        bat_sum_q;
	logic [CW-1:0]         bat_count_q;
	logic [SMP_W-1:0]      bat_level_q;

	logic                  advance;
	logic                  hp_upd;
	logic                  vol_upd;
	logic                  bat_upd;
	logic [SMP_W-1:0]      hp_level;
	logic [SMP_W-1:0]      vol_level;
	logic [SMP_W-1:0]      result_level;

	logic                  bat_start;
	logic                  bat_done;
	logic [BSW-1:0]        bat_sum_inc;
	logic [CW-1:0]         bat_count_inc;
	logic [BPRW-1:0]       bat_prod;
	logic [SMP_W-1:0]      bat_level_next;

	// The item in the input register moves on when the result register is free
	// or its item is being taken in this cycle.
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	assign hp_upd  = advance && (func_s1 == acaf_pkg::CH_HP);
	assign vol_upd = advance && (func_s1 == acaf_pkg::CH_VOL);
	assign bat_upd = advance && (func_s1 == acaf_pkg::CH_BAT);

	acaf_boxcar #(
		.TAPS   (HP_TAPS)
	) u_hp (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (hp_upd),
		.sample (sample_s1),
		.level  (hp_level)
	);

	acaf_boxcar #(
		.TAPS   (VOL_TAPS)
	) u_vol (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (vol_upd),
		.sample (sample_s1),
		.level  (vol_level)
	);

	// Battery block mean. A zero level with an empty block means no level has
	// been established yet (or the last mean was zero), so the raw sample is used.
	assign bat_start     = (bat_level_q == '0) && (bat_count_q == '0);
	assign bat_sum_inc   = bat_sum_q + BSW'(sample_s1);
	assign bat_count_inc = CW'(bat_count_q + 1'b1);
	assign bat_done      = !bat_start && (bat_count_inc == CW'(BAT_BLOCK));
	assign bat_prod      = BPRW'(BPRW'(bat_sum_inc) * BPRW'(BAT_RECIP));

	always_comb begin
		if (bat_start) begin
			bat_level_next = sample_s1;
		end else if (bat_done) begin
			bat_level_next = bat_prod[BSH +: SMP_W];
		end else begin
			bat_level_next = bat_level_q;
		end
	end

	always_comb begin
		unique case (func_s1)
			acaf_pkg::CH_HP:   result_level = hp_level;
			acaf_pkg::CH_VOL:  result_level = vol_level;
			acaf_pkg::CH_BAT:  result_level = bat_level_next;
			acaf_pkg::CH_NONE: result_level = '0;
			default:           result_level = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			func_s1   <= acaf_pkg::chan_t'(s_axis_tuser);
			sample_s1 <= s_axis_tdata[SMP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bat_sum_q   <= '0;
			bat_count_q <= '0;
			bat_level_q <= '0;
		end else if (bat_upd) begin
			bat_level_q <= bat_level_next;
			if (bat_start || bat_done) begin
				bat_sum_q   <= bat_done ? '0 : bat_sum_q;
				bat_count_q <= bat_done ? '0 : bat_count_q;
			end else begin
				bat_sum_q   <= bat_sum_inc;
				bat_count_q <= bat_count_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			channel_q <= func_s1;
			level_q   <= result_level;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = channel_q;
	assign m_axis_tdata  = acaf_pkg::DATA_W'(level_q);

endmodule

@@ tb/sv/tb_adc_channel_averaging_filter.sv @@
`timescale 1ns / 100ps

module tb_adc_channel_averaging_filter;

	localparam int HP_LEN       = acaf_pkg::HP_TAPS_DEF;
	localparam int VOL_LEN      = acaf_pkg::VOL_TAPS_DEF;
	localparam int BAT_LEN      = acaf_pkg::BAT_BLOCK_DEF;
	localparam int ITEMS_PER_PH = 275;
	localparam int STUCK_LIMIT  = 2000;
	localparam int SETTLE_CYC   = 10;
	localparam int N_DIRECTED   = 23;

	// One row of the directed sequence. When pinned is set, the level is known by
	// inspection and is checked as typed; otherwise the filter model decides it.
	typedef struct packed {
		acaf_pkg::chan_t func;
		logic [9:0]      sample;
		logic            pinned;
		logic [9:0]      level;
	} dir_row_t;

	typedef struct {
		acaf_pkg::chan_t channel;
		logic [9:0]      level;
	} level_item_t;

	localparam dir_row_t DIR_ROWS [0:N_DIRECTED-1] = '{
		'{acaf_pkg::CH_NONE, 10'h3FF, 1'b1, 10'd0},     // unused code reports zero
		'{acaf_pkg::CH_HP,   10'h3FF, 1'b1, 10'h3FF},   // first sample fills the window
		'{acaf_pkg::CH_HP,   10'd0,   1'b0, 10'd0},
		'{acaf_pkg::CH_HP,   10'd0,   1'b0, 10'd0},
		'{acaf_pkg::CH_HP,   10'd0,   1'b0, 10'd0},
		'{acaf_pkg::CH_VOL,  10'd0,   1'b1, 10'd0},
		'{acaf_pkg::CH_VOL,  10'h3FF, 1'b0, 10'd0},
		'{acaf_pkg::CH_BAT,  10'd0,   1'b1, 10'd0},     // start value of zero keeps start mode
		'{acaf_pkg::CH_BAT,  10'h3FF, 1'b1, 10'h3FF},   // start value taken directly
		'{acaf_pkg::CH_BAT,  10'd0,   1'b1, 10'h3FF},   // block fills, level holds
		'{acaf_pkg::CH_BAT,  10'd0,   1'b1, 10'h3FF},
		'{acaf_pkg::CH_BAT,  10'd0,   1'b1, 10'h3FF},
		'{acaf_pkg::CH_BAT,  10'd0,   1'b1, 10'h3FF},
		'{acaf_pkg::CH_BAT,  10'd0,   1'b1, 10'h3FF},
		'{acaf_pkg::CH_BAT,  10'd0,   1'b1, 10'h3FF},
		'{acaf_pkg::CH_BAT,  10'd0,   1'b1, 10'h3FF},
		'{acaf_pkg::CH_BAT,  10'd0,   1'b1, 10'h3FF},
		'{acaf_pkg::CH_BAT,  10'd0,   1'b1, 10'h3FF},
		'{acaf_pkg::CH_BAT,  10'd0,   1'b1, 10'h3FF},
		'{acaf_pkg::CH_BAT,  10'd0,   1'b1, 10'h3FF},
		'{acaf_pkg::CH_BAT,  10'd0,   1'b1, 10'd0},     // block mean of zero is stored
		'{acaf_pkg::CH_BAT,  10'd5,   1'b1, 10'd5},     // so the next sample restarts
		'{acaf_pkg::CH_NONE, 10'd0,   1'b1, 10'd0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	logic [acaf_pkg::DATA_W-1:0]   s_axis_tdata = '0;  // [9:0] sample, [15:10] zero
	logic [acaf_pkg::CHAN_W-1:0]   s_axis_tuser = '0;  // [1:0] func
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	logic [acaf_pkg::DATA_W-1:0]   m_axis_tdata;       // [9:0] level, [15:10] zero
	logic [acaf_pkg::CHAN_W-1:0]   m_axis_tuser;       // [1:0] channel

	int idle_pct = 0;
	int stall_pct = 0;
	int errors = 0;
	int stuck_cycles = 0;

	// Filter model state. Index 0 of the boxcar arrays is headphone sense,
	// index 1 is volume.
	int unsigned box_win [0:1][0:15] = '{default: '{default: 0}};
	int unsigned box_sum [0:1] = '{0, 0};
	int unsigned box_pos [0:1] = '{0, 0};
	bit          box_fresh [0:1] = '{1'b1, 1'b1};
	int unsigned bat_acc = 0;
	int unsigned bat_cnt = 0;
	int unsigned chan_level [0:2] = '{0, 0, 0};

	level_item_t expected_levels [$];
	dir_row_t    pinned_rows [$];

	adc_channel_averaging_filter DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Updates the model with one sample and returns the channel's new level.
	function automatic logic [9:0] filter_level(input acaf_pkg::chan_t ch,
		input logic [9:0] smp);
		int unsigned k;
		int unsigned taps;
		int unsigned i;
		int unsigned s;
		s = smp;
		case (ch) inside
			acaf_pkg::CH_HP, acaf_pkg::CH_VOL: begin
				k = (ch == acaf_pkg::CH_HP) ? 0 : 1;
				taps = (ch == acaf_pkg::CH_HP) ? HP_LEN : VOL_LEN;
				if (box_fresh[k]) begin
					// The first sample stands for the whole window.
					box_fresh[k] = 1'b0;
					for (i = 0; i < taps; i++)
						box_win[k][i] = s;
					box_pos[k] = 0;
					box_sum[k] = s * taps;
					chan_level[k] = s;
				end else begin
					box_sum[k] = box_sum[k] + s - box_win[k][box_pos[k]];
					box_win[k][box_pos[k]] = s;
					box_pos[k] = (box_pos[k] + 1 >= taps) ? 0 : box_pos[k] + 1;
					chan_level[k] = (box_sum[k] / taps) & 10'h3FF;
				end
				return chan_level[k][9:0];
			end
			acaf_pkg::CH_BAT: begin
				// A zero level with an empty block takes the sample as is.
				if (chan_level[2] == 0 && bat_cnt == 0) begin
					chan_level[2] = s;
				end else begin
					bat_acc += s;
					bat_cnt++;
				end
				if (bat_cnt >= BAT_LEN) begin
					chan_level[2] = (bat_acc / BAT_LEN) & 10'h3FF;
					bat_acc = 0;
					bat_cnt = 0;
				end
				return chan_level[2][9:0];
			end
			default: return 10'd0;
		endcase
	endfunction

	// Presents one item after a random gap and returns once it is accepted.
	task automatic send_sample(input logic [1:0] func, input logic [9:0] smp);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= func;
		s_axis_tdata  <= {6'd0, smp};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// Holds the input side idle until every expected level has come out.
	task automatic drain_levels();
		s_axis_tvalid <= 1'b0;
		while (expected_levels.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Scoreboard: both handshakes are sampled at the same edge, so accepted
	// items are turned into expectations before their results can appear.
	always @(posedge clk) begin : scoreboard
		level_item_t want;
		dir_row_t    row;
		logic [9:0]  lvl;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				lvl = filter_level(acaf_pkg::chan_t'(s_axis_tuser), s_axis_tdata[9:0]);
				if (pinned_rows.size() != 0) begin
					row = pinned_rows.pop_front();
					if (row.pinned)
						lvl = row.level;
				end
				expected_levels.push_back(
					level_item_t'{acaf_pkg::chan_t'(s_axis_tuser), lvl});
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_levels.size() == 0) begin
					$error("unexpected result: channel %0d level %0d",
						m_axis_tuser, m_axis_tdata[9:0]);
					errors++;
				end else begin
					want = expected_levels.pop_front();
					if (m_axis_tuser !== want.channel) begin
						$error("channel: expected %0d, got %0d", want.channel, m_axis_tuser);
						errors++;
					end
					if (m_axis_tdata[9:0] !== want.level) begin
						$error("level: expected %0d, got %0d", want.level, m_axis_tdata[9:0]);
						errors++;
					end
					if (m_axis_tdata[15:10] !== 6'd0) begin
						$error("pad: expected 0, got %0h", m_axis_tdata[15:10]);
						errors++;
					end
				end
			end
		end
	end

	// A long stretch with no accepted item on either side means a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				stuck_cycles <= 0;
			else
				stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		int          ph;
		int          n;
		int          run_len;
		int          style;
		logic [1:0]  run_func;
		logic [9:0]  smp;
		int          idle_set [0:3];
		int          stall_set [0:3];
		idle_set  = '{0, 76, 0, 35};
		stall_set = '{0, 0, 76, 35};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (ph = 0; ph < 4; ph++) begin
			idle_pct  = idle_set[ph];
			stall_pct = stall_set[ph];
			if (ph == 0) begin
				for (n = 0; n < N_DIRECTED; n++) begin
					pinned_rows.push_back(DIR_ROWS[n]);
					send_sample(DIR_ROWS[n].func, DIR_ROWS[n].sample);
				end
			end
			// Random part: runs on one channel, so that windows turn over and
			// battery blocks complete, with occasional unused-code items.
			n = 0;
			while (n < ITEMS_PER_PH) begin
				run_func = ($urandom_range(19) == 0) ? 2'(acaf_pkg::CH_NONE)
					: 2'($urandom_range(2));
				run_len  = $urandom_range(1, 16);
				style    = $urandom_range(3);
				repeat (run_len) begin
					case (style)
						0: smp = 10'($urandom_range(1023));
						1: smp = $urandom_range(1) ? 10'h3FF : 10'd0;
						2: smp = 10'($urandom_range(2));
						default: smp = 10'($urandom_range(1023, 1000));
					endcase
					send_sample(run_func, smp);
					n++;
				end
			end
			drain_levels();
		end

		repeat (SETTLE_CYC) @(posedge clk);
		if (expected_levels.size() != 0) begin
			$error("%0d expected results never arrived", expected_levels.size());
			errors++;
		end
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/acaf_pkg.sv
rtl/acaf_boxcar.sv
rtl/adc_channel_averaging_filter.sv
tb/sv/tb_adc_channel_averaging_filter.sv
